[rtl/skt_pkg.sv]
`timescale 1ns / 1ps

package skt_pkg;

  localparam int KEY_W    = 32;
  localparam int ACT_W    = 3;
  localparam int STATUS_W = 2;
  localparam int OUT_PW   = 64;

  // command codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LIST   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic             ins;
    logic             rot;
    logic [KEY_W-1:0] key;
  } skt_cmd_t;

endpackage

[rtl/skt_cell.sv]
`timescale 1ns / 1ps

module skt_cell import skt_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 5,
  parameter int PW  = 64
) (
  input  logic             clk,
  input  skt_cmd_t         cmd,
  input  logic [CW-1:0]    cnt,
  input  logic [PW-1:0]    new_pay,
  input  logic             prev_le,
  input  logic [KEY_W-1:0] prev_key,
  input  logic [PW-1:0]    prev_pay,
  input  logic [KEY_W-1:0] nb_key,
  input  logic [PW-1:0]    nb_pay,
  input  logic [KEY_W-1:0] wrap_key,
  input  logic [PW-1:0]    wrap_pay,
  output logic             le,
  output logic [KEY_W-1:0] key_q,
  output logic [PW-1:0]    pay_q
);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [PW-1:0]    pay_r, pay_nxt;
  logic             valid;
  logic             wrap_sel;

  assign valid    = CW'(IDX) < cnt;
  assign wrap_sel = CW'(IDX + 1) == cnt;
  // entry sorts at or before the new key: it stays where it is
  assign le       = valid && ($signed(key_r) <= $signed(cmd.key));

  always_comb begin
    key_nxt = key_r;
    pay_nxt = pay_r;
    if (cmd.ins) begin
      if (!le) begin
        if (prev_le) begin
          key_nxt = cmd.key;
          pay_nxt = new_pay;
        end else begin
          key_nxt = prev_key;
          pay_nxt = prev_pay;
        end
      end
    end else if (cmd.rot) begin
      if (wrap_sel) begin
        key_nxt = wrap_key;
        pay_nxt = wrap_pay;
      end else begin
        key_nxt = nb_key;
        pay_nxt = nb_pay;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pay_r <= pay_nxt;
  end

  assign key_q = key_r;
  assign pay_q = pay_r;

endmodule

[rtl/sorted_key_table_top.sv]
`timescale 1ns / 1ps

// channel   dir  handshake             tdata (low bit up)              tuser / tlast
// in_       in   in_tvalid/in_tready   key[31:0], payload[95:32]       tuser action[2:0]
// out_      out  out_tvalid/out_tready entry_key[31:0], payload[95:32] tuser status[1:0],
//                                                                      several[2]; tlast last
//
// insert, full table, empty table and unknown commands finish in the accept cycle
// lookup, update and delete rotate the cell ring once, one step per entry, then
//   load the result word from S_DONE
// list emits one word per ring step
// an output stall freezes the ring during list and holds off the next command
// reset clears the entry count and the control only; cell contents are left as they are

module sorted_key_table_top import skt_pkg::*; #(
  parameter int CAPACITY      = 16,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // key[31:0], payload[95:32]
  input  logic [2:0]  in_tuser,   // action[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // entry_key[31:0], entry_payload[95:32]
  output logic [2:0]  out_tuser,  // status[1:0], several_matches[2]
  output logic        out_tlast
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = PAYLOAD_WIDTH;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t               state_r;
  logic [ACT_W-1:0]     op_r;
  logic [KEY_W-1:0]     cmd_key_r;
  logic [PW-1:0]        cmd_pay_r;
  logic [CW-1:0]        n_r;
  logic [CW-1:0]        step_r;
  logic [CW-1:0]        cnt_r;
  logic                 found_r;
  logic                 chk_r;
  logic                 sev_r;
  logic [PW-1:0]        res_pay_r;

  logic                 out_valid_r;
  logic [KEY_W-1:0]     out_key_r;
  logic [OUT_PW-1:0]    out_pay_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic                 out_sev_r;
  logic                 out_last_r;

  logic [ACT_W-1:0]     in_act;
  logic [KEY_W-1:0]     in_key;
  logic [PW-1:0]        in_pay_m;
  logic                 out_free;
  logic                 out_load;
  logic                 acc;
  logic                 hit;
  logic                 first_hit;
  logic                 scan_go;
  logic                 scan_end;
  logic                 is_full;
  logic [PW-1:0]        wrap_pay;
  skt_cmd_t             cmd;

  // the cell chain
  logic [KEY_W-1:0]     ck [CAPACITY];
  logic [PW-1:0]        cp [CAPACITY];
  logic                 cle [CAPACITY];

  assign in_act   = in_tuser[2:0];
  assign in_key   = in_tdata[31:0];
  assign in_pay_m = in_tdata[32 +: PW];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign acc       = in_tvalid && in_tready;
  assign is_full   = cnt_r == CW'(CAPACITY);

  // cell 0 is the head of the ring; each scan step looks at it
  assign hit       = ck[0] == cmd_key_r;
  assign first_hit = hit && !found_r;
  assign scan_go   = (state_r == S_SCAN) && ((op_r != ACT_LIST) || out_free);
  assign scan_end  = step_r == (n_r - CW'(1));

  // update rewrites the payload as the matching entry wraps to the tail
  assign wrap_pay  = ((op_r == ACT_UPDATE) && first_hit) ? cmd_pay_r : cp[0];

  // a new result word is loaded into the output register this cycle
  always_comb begin
    case (state_r)
      S_IDLE: begin
        out_load = acc && (in_act <= ACT_DELETE) &&
                   ((in_act == ACT_INSERT) || (cnt_r == '0));
      end
      S_SCAN: begin
        out_load = scan_go && (op_r == ACT_LIST);
      end
      S_DONE: begin
        out_load = out_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  assign cmd.ins = acc && (in_act == ACT_INSERT) && !is_full;
  assign cmd.rot = scan_go;
  assign cmd.key = in_key;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             p_le;
    logic [KEY_W-1:0] p_key;
    logic [PW-1:0]    p_pay;
    logic [KEY_W-1:0] n_key;
    logic [PW-1:0]    n_pay;

    if (i == 0) begin : g_first
      // the slot before the head acts as minus infinity
      assign p_le  = 1'b1;
      assign p_key = '0;
      assign p_pay = '0;
    end else begin : g_mid
      assign p_le  = cle[i-1];
      assign p_key = ck[i-1];
      assign p_pay = cp[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign n_key = '0;
      assign n_pay = '0;
    end else begin : g_body
      assign n_key = ck[i+1];
      assign n_pay = cp[i+1];
    end

    skt_cell #(
      .IDX (i),
      .CW  (CW),
      .PW  (PW)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .cnt      (cnt_r),
      .new_pay  (in_pay_m),
      .prev_le  (p_le),
      .prev_key (p_key),
      .prev_pay (p_pay),
      .nb_key   (n_key),
      .nb_pay   (n_pay),
      .wrap_key (ck[0]),
      .wrap_pay (wrap_pay),
      .le       (cle[i]),
      .key_q    (ck[i]),
      .pay_q    (cp[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      chk_r       <= 1'b0;
      sev_r       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            op_r      <= in_act;
            cmd_key_r <= in_key;
            cmd_pay_r <= in_pay_m;
            n_r       <= cnt_r;
            step_r    <= '0;
            found_r   <= 1'b0;
            chk_r     <= 1'b0;
            sev_r     <= 1'b0;
            case (in_act)
              ACT_INSERT: begin
                out_sev_r   <= 1'b0;
                out_last_r  <= 1'b1;
                if (is_full) begin
                  out_status_r <= ST_FULL;
                  out_key_r    <= '0;
                  out_pay_r    <= '0;
                end else begin
                  out_status_r <= ST_OK;
                  out_key_r    <= in_key;
                  out_pay_r    <= OUT_PW'(in_pay_m);
                  cnt_r        <= cnt_r + CW'(1);
                end
              end
              ACT_LOOKUP, ACT_LIST, ACT_UPDATE, ACT_DELETE: begin
                if (cnt_r == '0) begin
                  out_status_r <= ST_EMPTY;
                  out_key_r    <= '0;
                  out_pay_r    <= '0;
                  out_sev_r    <= 1'b0;
                  out_last_r   <= 1'b1;
                end else begin
                  state_r <= S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_SCAN: begin
          if (scan_go) begin
            step_r <= step_r + CW'(1);
            if (scan_end) begin
              state_r <= (op_r == ACT_LIST) ? S_IDLE : S_DONE;
            end
            case (op_r)
              ACT_LIST: begin
                out_status_r <= ST_OK;
                out_key_r    <= ck[0];
                out_pay_r    <= OUT_PW'(cp[0]);
                out_sev_r    <= 1'b0;
                out_last_r   <= scan_end;
              end
              ACT_LOOKUP: begin
                // the step after the first match checks for a duplicate
                if (chk_r) begin
                  sev_r <= hit;
                  chk_r <= 1'b0;
                end
                if (first_hit) begin
                  found_r   <= 1'b1;
                  res_pay_r <= cp[0];
                  chk_r     <= 1'b1;
                end
              end
              ACT_UPDATE: begin
                if (first_hit) begin
                  found_r   <= 1'b1;
                  res_pay_r <= cmd_pay_r;
                end
              end
              ACT_DELETE: begin
                // dropping the head: ring shrinks by one, rest keeps rotating
                if (first_hit) begin
                  found_r   <= 1'b1;
                  res_pay_r <= cp[0];
                  cnt_r     <= cnt_r - CW'(1);
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
            if (found_r) begin
              out_status_r <= ST_OK;
              out_key_r    <= cmd_key_r;
              out_pay_r    <= OUT_PW'(res_pay_r);
              out_sev_r    <= (op_r == ACT_LOOKUP) && sev_r;
            end else begin
              out_status_r <= ST_MISS;
              out_key_r    <= '0;
              out_pay_r    <= '0;
              out_sev_r    <= 1'b0;
            end
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pay_r, out_key_r};
  assign out_tuser  = {out_sev_r, out_status_r};
  assign out_tlast  = out_last_r;

endmodule

[rtl/skt_checker.sv]
`timescale 1ns / 1ps

module skt_checker import skt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  // a stalled word keeps its contents
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser)
                                  && $stable(out_tlast))
    else $error("output word changed while stalled");

  // error words are single, zeroed and closing
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] != ST_OK) |->
      (out_tdata == '0) && !out_tuser[2] && out_tlast)
    else $error("error word carries data or is not last");

  // no new command while the output is blocked
  a_no_accept_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("command accepted while output stalled");

endmodule

bind sorted_key_table_top skt_checker u_skt_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top import skt_pkg::*; ();

  localparam int          TABLE_DEPTH = 16;
  localparam int          PAY_W       = 64;
  localparam logic [63:0] PAY_MASK    = {64{1'b1}} >> (64 - PAY_W);
  localparam int          IDLE_PCT    = 18;
  localparam int          DRAIN_WAIT  = 40;

  localparam logic [31:0] KEY_POOL [6] = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                                            32'h0000_0000, 32'h0000_0001, 32'h0000_0005};

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [31:0]      key;
    logic [63:0]      payload;
  } command_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [31:0]         key;
    logic [63:0]         payload;
    logic                several;
    logic                last;
  } table_word_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  command_t    command_q [$];
  table_word_t expected_words [$];
  int          mismatches = 0;
  int          accepted   = 0;
  logic        calm;

  // shadow copy of the table
  logic [31:0] shadow_keys [TABLE_DEPTH];
  logic [63:0] shadow_pays [TABLE_DEPTH];
  int          shadow_count = 0;

  sorted_key_table_top #(
    .CAPACITY     (TABLE_DEPTH),
    .PAYLOAD_WIDTH(PAY_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // no idling on either side while this window of commands goes through
  assign calm = (accepted >= 70) && (accepted < 100);

  task automatic report_mismatch(input string what);
    if (mismatches < 50) $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic table_word_t make_word(input logic [STATUS_W-1:0] st, input logic [31:0] k,
                                            input logic [63:0] p, input logic sev,
                                            input logic lst);
    table_word_t w;
    w.status  = st;
    w.key     = k;
    w.payload = p;
    w.several = sev;
    w.last    = lst;
    return w;
  endfunction

  // run one command against the shadow table and queue the words it must produce
  task automatic apply_command(input logic [ACT_W-1:0] act, input logic [31:0] k,
                               input logic [63:0] raw_pay);
    logic [63:0] p;
    int          pos;
    int          i;
    logic        sev;
    p = raw_pay & PAY_MASK;
    if (act > ACT_DELETE) return;
    if (act == ACT_INSERT) begin
      if (shadow_count >= TABLE_DEPTH) begin
        expected_words.push_back(make_word(ST_FULL, '0, '0, 1'b0, 1'b1));
        return;
      end
      // new entry goes after every equal key
      pos = 0;
      while (pos < shadow_count && $signed(shadow_keys[pos]) <= $signed(k)) pos++;
      for (i = shadow_count; i > pos; i--) begin
        shadow_keys[i] = shadow_keys[i-1];
        shadow_pays[i] = shadow_pays[i-1];
      end
      shadow_keys[pos] = k;
      shadow_pays[pos] = p;
      shadow_count++;
      expected_words.push_back(make_word(ST_OK, k, p, 1'b0, 1'b1));
      return;
    end
    if (shadow_count == 0) begin
      expected_words.push_back(make_word(ST_EMPTY, '0, '0, 1'b0, 1'b1));
      return;
    end
    if (act == ACT_LIST) begin
      for (i = 0; i < shadow_count; i++)
        expected_words.push_back(make_word(ST_OK, shadow_keys[i], shadow_pays[i], 1'b0,
                                           i == shadow_count - 1));
      return;
    end
    pos = 0;
    while (pos < shadow_count && shadow_keys[pos] != k) pos++;
    if (pos >= shadow_count) begin
      expected_words.push_back(make_word(ST_MISS, '0, '0, 1'b0, 1'b1));
      return;
    end
    case (act)
      ACT_LOOKUP: begin
        sev = (pos + 1 < shadow_count) && (shadow_keys[pos+1] == k);
        expected_words.push_back(make_word(ST_OK, k, shadow_pays[pos], sev, 1'b1));
      end
      ACT_UPDATE: begin
        shadow_pays[pos] = p;
        expected_words.push_back(make_word(ST_OK, k, p, 1'b0, 1'b1));
      end
      default: begin
        expected_words.push_back(make_word(ST_OK, k, shadow_pays[pos], 1'b0, 1'b1));
        for (i = pos; i + 1 < shadow_count; i++) begin
          shadow_keys[i] = shadow_keys[i+1];
          shadow_pays[i] = shadow_pays[i+1];
        end
        shadow_count--;
      end
    endcase
  endtask

  task automatic queue_command(input logic [ACT_W-1:0] act, input logic [31:0] k,
                               input logic [63:0] p);
    command_t c;
    c.action  = act;
    c.key     = k;
    c.payload = p;
    command_q.push_back(c);
  endtask

  // mostly keys from a small pool so that hits and duplicates are common
  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) < 8) return KEY_POOL[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  function automatic logic [63:0] pick_payload();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ACT_W-1:0] pick_action(input int ins_pct, input int del_pct);
    int r;
    int s;
    r = $urandom_range(0, 99);
    if (r < ins_pct) return ACT_INSERT;
    if (r < ins_pct + del_pct) return ACT_DELETE;
    s = $urandom_range(0, 9);
    if (s < 4) return ACT_LOOKUP;
    if (s < 7) return ACT_UPDATE;
    if (s < 9) return ACT_LIST;
    return ACT_W'($urandom_range(5, 7));
  endfunction

  // input side: one word per handshake, random gaps between words
  always @(posedge clk) begin : drive_commands
    command_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_command(in_tuser, in_tdata[31:0], in_tdata[95:32]);
        accepted <= accepted + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (command_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          c = command_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= c.action;
          in_tdata  <= {c.payload, c.key};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side: compare every accepted word with the oldest expected one
  always @(posedge clk) begin : check_words
    table_word_t got;
    table_word_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = make_word(out_tuser[1:0], out_tdata[31:0], out_tdata[95:32], out_tuser[2],
                        out_tlast);
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word key=%h status=%0d", got.key, got.status));
        end else begin
          want = expected_words.pop_front();
          if (got.status != want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.key != want.key)
            report_mismatch($sformatf("key %h, want %h", got.key, want.key));
          if (got.payload != want.payload)
            report_mismatch($sformatf("payload %h, want %h", got.payload, want.payload));
          if (got.several != want.several)
            report_mismatch($sformatf("several %b, want %b", got.several, want.several));
          if (got.last != want.last)
            report_mismatch($sformatf("last %b, want %b", got.last, want.last));
        end
      end
      out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    int n;
    int phase;
    // empty table: every command but insert
    queue_command(ACT_LOOKUP, 32'h0000_0005, '0);
    queue_command(ACT_UPDATE, 32'h0000_0005, '1);
    queue_command(ACT_DELETE, 32'h0000_0005, '0);
    queue_command(ACT_LIST,   32'h0000_0000, '0);
    // key and payload extremes, then a run of equal keys
    queue_command(ACT_INSERT, 32'h7fff_ffff, '0);
    queue_command(ACT_INSERT, 32'h8000_0000, '1);
    queue_command(ACT_INSERT, 32'h0000_0000, 64'h0123_4567_89ab_cdef);
    queue_command(ACT_INSERT, 32'hffff_ffff, 64'hfedc_ba98_7654_3210);
    queue_command(ACT_INSERT, 32'h0000_0005, 64'h1111);
    queue_command(ACT_INSERT, 32'h0000_0005, 64'h2222);
    queue_command(ACT_INSERT, 32'h0000_0005, 64'h3333);
    queue_command(ACT_LOOKUP, 32'h0000_0005, '0);
    queue_command(ACT_LOOKUP, 32'h7fff_ffff, '0);
    queue_command(ACT_LOOKUP, 32'h0000_0007, '0);
    queue_command(ACT_UPDATE, 32'h0000_0005, 64'haaaa_5555_aaaa_5555);
    queue_command(ACT_UPDATE, 32'h0000_0007, '1);
    queue_command(ACT_DELETE, 32'h0000_0005, '0);
    queue_command(ACT_DELETE, 32'h0000_0007, '0);
    queue_command(ACT_LIST,   32'h0000_0000, '0);
    // unknown commands give no word
    queue_command(3'd5, 32'h0000_0005, '1);
    queue_command(3'd6, 32'h8000_0000, '0);
    queue_command(3'd7, 32'hffff_ffff, '1);
    // random part: fill to full, drain toward empty, then two mixed phases
    for (phase = 0; phase < 4; phase++) begin
      for (n = 0; n < 27; n++) begin
        case (phase)
          0:       queue_command(pick_action(85, 5),  pick_key(), pick_payload());
          1:       queue_command(pick_action(10, 60), pick_key(), pick_payload());
          default: queue_command(pick_action(35, 20), pick_key(), pick_payload());
        endcase
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (command_q.size() > 0 || in_tvalid || expected_words.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
